// File: rtl/weighted_degree_string_kernel_top_assert.svh
// Assertion macros used by the checker of the string kernel block
`ifndef WEIGHTED_DEGREE_STRING_KERNEL_TOP_ASSERT_SVH
`define WEIGHTED_DEGREE_STRING_KERNEL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WDSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WDSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wdsk_pkg.sv
// Package: types, codes and constants of the weighted degree string kernel
package wdsk_pkg;

  localparam int MAX_LEN_DEF        = 256;
  localparam int MAX_DEGREE_DEF     = 16;
  localparam int WEIGHT_DEPTH_DEF   = 4096;
  localparam int MISMATCH_LIMIT_DEF = 3;

  localparam int ACC_W     = 48;
  localparam int PART_W    = 40;
  localparam int TBL_W     = 32;
  localparam int PART_LO_W = 20;
  localparam int PART_HI_W = PART_W - PART_LO_W;
  localparam int PROD_W    = PART_W + TBL_W;
  localparam int FRAC_W    = 16;
  localparam int CL_W      = PROD_W - FRAC_W;
  localparam int LEN_OUT_W = 9;
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [1:0] FUNC_CMP = 2'd0;
  localparam logic [1:0] FUNC_WT  = 2'd1;
  localparam logic [1:0] FUNC_POS = 2'd2;
  localparam logic [1:0] FUNC_BLK = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_DEGREE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_MM    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_EN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POS_MATRIX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POS_SCALE = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         sym_a;
    logic [7:0]         sym_b;
    logic               end_of_string;
    logic [11:0]        table_index;
    logic signed [31:0] table_value;
  } item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] kernel_value;
    logic [LEN_OUT_W-1:0]    string_length;
    logic                    overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLK_RD,
    ST_BLK_ADD,
    ST_OPEN,
    ST_WIN_CHECK,
    ST_WIN_ADD,
    ST_WIN_NEXT,
    ST_CL_START,
    ST_CL_MLO,
    ST_CL_MHI,
    ST_CL_SUM,
    ST_CL_ADD,
    ST_FL_CHK,
    ST_FL_NEXT,
    ST_FL_RUN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/wdsk_ram.sv
// Generic single-write, single-read RAM with registered read data
module wdsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/weighted_degree_string_kernel_top.sv
// Top level of the weighted degree string kernel with mismatches
//
// Items enter on the item channel (valid/ready). func 0 carries one symbol
// pair of the two strings; funcs 1, 2 and 3 write the weight, position weight
// and block weight tables and give no result. A pair with end_of_string set
// closes the string, and one result (kernel sum, length, overflow) follows on
// the result channel (valid/ready) from an output register.
// In block mode a pair that ends a run also reads and adds the block weight
// of that run. In window mode a pair first closes its slot's old window and
// opens a new one, then sweeps all MAX_DEGREE window slots; each live window
// reads the shared weight memory once, and a window that closes adds its sum,
// scaled by its position weight when scaling is on. The end of a string sweeps
// the slots again to close the live windows, adds the block weight of an open
// run and loads the output register.
// Item ready is high only while the sequencer is idle; a result waiting in
// the output register does not stop new items, but the next result holds
// until the receiver takes the current one.
// Synchronous reset clears the string state and sets the registers to their
// defaults; the tables keep no reset value and must be written before use.
module weighted_degree_string_kernel_top #(
  parameter int MAX_LEN        = wdsk_pkg::MAX_LEN_DEF,
  parameter int MAX_DEGREE     = wdsk_pkg::MAX_DEGREE_DEF,
  parameter int WEIGHT_DEPTH   = wdsk_pkg::WEIGHT_DEPTH_DEF,
  parameter int MISMATCH_LIMIT = wdsk_pkg::MISMATCH_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  wdsk_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output wdsk_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wdsk_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wdsk_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int WA_W   = $clog2(WEIGHT_DEPTH);
  localparam int IDX_W  = LEN_W + DEG_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_DEGREE - 1);

  // Configuration registers
  logic [4:0] cfg_degree;
  logic [1:0] cfg_max_mm;
  logic       cfg_block_en;
  logic       cfg_pos_matrix;
  logic       cfg_pos_scale;

  // Sequencer and string state
  state_t state, state_next, ret;
  logic [MAX_DEGREE-1:0]   alive;
  logic [LEN_W-1:0]        win_start   [MAX_DEGREE];
  logic [DEG_W-1:0]        win_off     [MAX_DEGREE];
  logic [1:0]              win_mism    [MAX_DEGREE];
  logic signed [PART_W-1:0] win_partial [MAX_DEGREE];
  logic [CNT_W-1:0]        pos;
  logic [LEN_W-1:0]        cur_pos;
  logic [SLOT_W-1:0]       slot, cur_slot, k;
  logic                    run_valid;
  logic [LEN_W-1:0]        run;
  logic signed [ACC_W-1:0] acc;
  logic                    ovf;
  logic                    eq_q, eos_q, idx_ok;
  logic signed [TBL_W-1:0] w_q;
  logic signed [PART_LO_W+TBL_W:0] prod_lo;
  logic signed [PART_HI_W+TBL_W-1:0] prod_hi;
  logic signed [CL_W-1:0]  cl_value;
  logic                    out_valid;
  result_t                 out_data;

  // Memory ports
  logic             wt_we, pw_we, bw_we;
  logic [WA_W-1:0]  wt_raddr;
  logic [LEN_W-1:0] pw_raddr, bw_raddr;
  logic [TBL_W-1:0] wt_rdata, pw_rdata, bw_rdata;

  // Derived control values
  logic [DEG_W-1:0]  deg_eff;
  logic [1:0]        mm_eff;
  logic              block_mode, matrix_mode, pos_full, in_cmp;
  logic [2:0]        m_inc;
  logic              close_mm;
  logic [1:0]        m_use;
  logic [IDX_W-1:0]  idx;
  logic [DEG_W:0]    off_inc;
  logic              off_done;
  logic signed [CL_W-1:0]  add_op;
  logic signed [CL_W:0]    acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic                    sat_hit;
  logic signed [PROD_W-1:0] prod_full;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_DEGREE:     prdata = {27'd0, cfg_degree};
      REG_MAX_MM:     prdata = {30'd0, cfg_max_mm};
      REG_BLOCK_EN:   prdata = {31'd0, cfg_block_en};
      REG_POS_MATRIX: prdata = {31'd0, cfg_pos_matrix};
      REG_POS_SCALE:  prdata = {31'd0, cfg_pos_scale};
      default:        prdata = 32'd0;
    endcase
  end

  // Clamp the registers to the supported range and pick the mode
  always_comb begin
    if (cfg_degree == 5'd0) begin
      deg_eff = DEG_W'(1);
    end else if (32'(cfg_degree) > 32'(MAX_DEGREE)) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = DEG_W'(cfg_degree);
    end
    if (32'(cfg_max_mm) > 32'(MISMATCH_LIMIT)) begin
      mm_eff = 2'(MISMATCH_LIMIT);
    end else begin
      mm_eff = cfg_max_mm;
    end
  end

  assign block_mode  = (mm_eff == 2'd0) && !cfg_pos_matrix && cfg_block_en;
  assign matrix_mode = (mm_eff == 2'd0) && cfg_pos_matrix;
  assign pos_full    = pos >= CNT_W'(MAX_LEN);
  assign in_cmp      = item_valid && (item.func == FUNC_CMP);

  // Window step: mismatch count, weight index, end of window
  assign m_inc    = {1'b0, win_mism[k]} + 3'd1;
  assign close_mm = !eq_q && (m_inc > {1'b0, mm_eff});
  assign m_use    = eq_q ? win_mism[k] : m_inc[1:0];
  always_comb begin
    if (matrix_mode) begin
      idx = IDX_W'(win_start[k]) * IDX_W'(deg_eff) + IDX_W'(win_off[k]);
    end else begin
      idx = IDX_W'(win_off[k]) + IDX_W'(deg_eff) * IDX_W'(m_use);
    end
  end
  assign off_inc  = {1'b0, win_off[k]} + {{DEG_W{1'b0}}, 1'b1};
  assign off_done = off_inc >= {1'b0, deg_eff};

  // Rebuild the scaled window sum from its two partial products
  assign prod_full = ({{(PROD_W-PART_HI_W-TBL_W){prod_hi[PART_HI_W+TBL_W-1]}}, prod_hi}
                      <<< PART_LO_W)
                   + {{(PROD_W-PART_LO_W-TBL_W-1){prod_lo[PART_LO_W+TBL_W]}}, prod_lo};

  // Saturating accumulate of a window sum or a block weight
  always_comb begin
    if (state == ST_BLK_ADD) begin
      add_op = {{(CL_W-TBL_W){bw_rdata[TBL_W-1]}}, bw_rdata};
    end else begin
      add_op = cl_value;
    end
    acc_sum = {{(CL_W+1-ACC_W){acc[ACC_W-1]}}, acc} + {add_op[CL_W-1], add_op};
    sat_hit = (acc_sum[CL_W:ACC_W-1] != '0) && (acc_sum[CL_W:ACC_W-1] != '1);
    if (!sat_hit) begin
      acc_sat = acc_sum[ACC_W-1:0];
    end else if (acc_sum[CL_W]) begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_cmp) begin
          if (pos_full) begin
            state_next = item.end_of_string ? ST_FL_CHK : ST_IDLE;
          end else if (block_mode) begin
            if ((item.sym_a != item.sym_b) && run_valid) begin
              state_next = ST_BLK_RD;
            end else begin
              state_next = item.end_of_string ? ST_FL_CHK : ST_IDLE;
            end
          end else begin
            state_next = ST_OPEN;
          end
        end
      end
      ST_BLK_RD:  state_next = ST_BLK_ADD;
      ST_BLK_ADD: state_next = ret;
      ST_OPEN:    state_next = alive[cur_slot] ? ST_CL_START : ST_WIN_CHECK;
      ST_WIN_CHECK: begin
        if (!alive[k]) begin
          state_next = ST_WIN_NEXT;
        end else if (close_mm) begin
          state_next = ST_CL_START;
        end else begin
          state_next = ST_WIN_ADD;
        end
      end
      ST_WIN_ADD: state_next = off_done ? ST_CL_START : ST_WIN_NEXT;
      ST_WIN_NEXT: begin
        if (k == SLOT_LAST) begin
          state_next = eos_q ? ST_FL_CHK : ST_IDLE;
        end else begin
          state_next = ST_WIN_CHECK;
        end
      end
      ST_CL_START: state_next = cfg_pos_scale ? ST_CL_MLO : ST_CL_ADD;
      ST_CL_MLO:   state_next = ST_CL_MHI;
      ST_CL_MHI:   state_next = ST_CL_SUM;
      ST_CL_SUM:   state_next = ST_CL_ADD;
      ST_CL_ADD:   state_next = ret;
      ST_FL_CHK:   state_next = alive[k] ? ST_CL_START : ST_FL_NEXT;
      ST_FL_NEXT:  state_next = (k == SLOT_LAST) ? ST_FL_RUN : ST_FL_CHK;
      ST_FL_RUN:   state_next = run_valid ? ST_BLK_RD : ST_EMIT;
      ST_EMIT:     state_next = (!out_valid || result_ready) ? ST_IDLE : ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory port outputs
  always_comb begin
    item_ready = (state == ST_IDLE);
    wt_we      = item_valid && item_ready && (item.func == FUNC_WT)
                 && (32'(item.table_index) < 32'(WEIGHT_DEPTH));
    pw_we      = item_valid && item_ready && (item.func == FUNC_POS)
                 && (32'(item.table_index) < 32'(MAX_LEN));
    bw_we      = item_valid && item_ready && (item.func == FUNC_BLK)
                 && (32'(item.table_index) < 32'(MAX_LEN));
    wt_raddr   = idx[WA_W-1:0];
    pw_raddr   = win_start[k];
    bw_raddr   = run;
  end

  assign result_valid = out_valid;
  assign result       = out_data;

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cfg_degree     <= 5'd1;
      cfg_max_mm     <= 2'd0;
      cfg_block_en   <= 1'b0;
      cfg_pos_matrix <= 1'b0;
      cfg_pos_scale  <= 1'b0;
      alive          <= '0;
      pos            <= '0;
      slot           <= '0;
      run_valid      <= 1'b0;
      acc            <= '0;
      ovf            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration transfer
      if (cfg_wr) begin
        case (cfg_idx)
          REG_DEGREE:     cfg_degree     <= pwdata[4:0];
          REG_MAX_MM:     cfg_max_mm     <= pwdata[1:0];
          REG_BLOCK_EN:   cfg_block_en   <= pwdata[0];
          REG_POS_MATRIX: cfg_pos_matrix <= pwdata[0];
          REG_POS_SCALE:  cfg_pos_scale  <= pwdata[0];
          default: ;
        endcase
      end

      // Drop the result once transferred, unless a new one replaces it
      if (out_valid && result_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_cmp) begin
            eq_q  <= item.sym_a == item.sym_b;
            eos_q <= item.end_of_string;
            k     <= '0;
            if (pos_full) begin
              ovf <= 1'b1;
            end else begin
              pos      <= pos + CNT_W'(1);
              cur_pos  <= LEN_W'(pos);
              cur_slot <= slot;
              slot     <= (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
              if (block_mode) begin
                if (item.sym_a == item.sym_b) begin
                  if (run_valid) begin
                    run <= run + LEN_W'(1);
                  end else begin
                    run_valid <= 1'b1;
                    run       <= '0;
                  end
                end else begin
                  ret <= item.end_of_string ? ST_FL_CHK : ST_IDLE;
                end
              end
            end
          end
        end
        ST_BLK_ADD: begin
          acc       <= acc_sat;
          ovf       <= ovf | sat_hit;
          run_valid <= 1'b0;
          k         <= '0;
        end
        ST_OPEN: begin
          // Close the slot's previous window first, then open it afresh
          if (alive[cur_slot]) begin
            k   <= cur_slot;
            ret <= ST_OPEN;
          end else begin
            alive[cur_slot]       <= 1'b1;
            win_start[cur_slot]   <= cur_pos;
            win_off[cur_slot]     <= '0;
            win_mism[cur_slot]    <= 2'd0;
            win_partial[cur_slot] <= '0;
            k                     <= '0;
          end
        end
        ST_WIN_CHECK: begin
          if (alive[k]) begin
            if (close_mm) begin
              ret <= ST_WIN_NEXT;
            end else begin
              win_mism[k] <= m_use;
              idx_ok      <= 32'(idx) < 32'(WEIGHT_DEPTH);
            end
          end
        end
        ST_WIN_ADD: begin
          if (idx_ok) begin
            win_partial[k] <= win_partial[k]
                              + {{(PART_W-TBL_W){wt_rdata[TBL_W-1]}}, wt_rdata};
          end
          win_off[k] <= off_inc[DEG_W-1:0];
          ret        <= ST_WIN_NEXT;
        end
        ST_WIN_NEXT: begin
          k <= (k == SLOT_LAST) ? '0 : k + SLOT_W'(1);
        end
        ST_CL_START: begin
          cl_value <= {{(CL_W-PART_W){win_partial[k][PART_W-1]}}, win_partial[k]};
        end
        ST_CL_MLO: begin
          w_q     <= pw_rdata;
          prod_lo <= $signed({1'b0, win_partial[k][PART_LO_W-1:0]}) * $signed(pw_rdata);
        end
        ST_CL_MHI: begin
          prod_hi <= $signed(win_partial[k][PART_W-1:PART_LO_W]) * w_q;
        end
        ST_CL_SUM: begin
          cl_value <= prod_full[PROD_W-1:FRAC_W];
        end
        ST_CL_ADD: begin
          acc      <= acc_sat;
          ovf      <= ovf | sat_hit;
          alive[k] <= 1'b0;
        end
        ST_FL_CHK: begin
          if (alive[k]) begin
            ret <= ST_FL_NEXT;
          end
        end
        ST_FL_NEXT: begin
          if (k != SLOT_LAST) begin
            k <= k + SLOT_W'(1);
          end
        end
        ST_FL_RUN: begin
          ret <= ST_EMIT;
        end
        ST_EMIT: begin
          // Load the result and clear the string state
          if (!out_valid || result_ready) begin
            out_valid              <= 1'b1;
            out_data.kernel_value  <= acc;
            out_data.string_length <= LEN_OUT_W'(pos);
            out_data.overflow      <= ovf;
            alive                  <= '0;
            pos                    <= '0;
            slot                   <= '0;
            run_valid              <= 1'b0;
            acc                    <= '0;
            ovf                    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Weight tables
  wdsk_ram #(.WIDTH(TBL_W), .DEPTH(WEIGHT_DEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (WA_W'(item.table_index)),
    .wdata (item.table_value),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  wdsk_ram #(.WIDTH(TBL_W), .DEPTH(MAX_LEN)) u_pw_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (LEN_W'(item.table_index)),
    .wdata (item.table_value),
    .raddr (pw_raddr),
    .rdata (pw_rdata)
  );

  wdsk_ram #(.WIDTH(TBL_W), .DEPTH(MAX_LEN)) u_bw_ram (
    .clk   (clk),
    .we    (bw_we),
    .waddr (LEN_W'(item.table_index)),
    .wdata (item.table_value),
    .raddr (bw_raddr),
    .rdata (bw_rdata)
  );

endmodule

// File: rtl/wdsk_checker.sv
// Port checker of the string kernel top level, with its bind
`include "weighted_degree_string_kernel_top_assert.svh"

module wdsk_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input wdsk_pkg::result_t           result,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [wdsk_pkg::CFG_AW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import wdsk_pkg::*;

  // Config port never stalls
  `WDSK_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready low")

  // Hold a stalled result
  `WDSK_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result), "stalled result changed")

  // A result never appears straight after an item transfer
  `WDSK_ASSERT_NOW(a_result_not_after_item, $rose(result_valid),
    !$past(item_valid && item_ready), "result right after item transfer")

  // Degree register reads back what was written
  `WDSK_ASSERT_NEXT(a_degree_readback,
    psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == REG_DEGREE),
    !(paddr[CFG_AW-1:2] == REG_DEGREE) || (prdata[4:0] == $past(pwdata[4:0])),
    "degree read-back mismatch")

endmodule

bind weighted_degree_string_kernel_top wdsk_checker u_wdsk_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready)
);

// File: test/tb_top.sv
// Self-checking testbench of the weighted degree string kernel block
`timescale 1ns / 100ps

// Predicts kernel results from accepted items and checks the result stream
class kernel_scoreboard;
  logic [31:0] wt_mem [4096];
  logic [31:0] pos_mem [256];
  logic [31:0] blk_mem [256];
  int          win_start [16];
  int          win_off [16];
  int          win_mm [16];
  bit          win_live [16];
  longint      win_sum [16];
  int          pair_count;
  int          run_len;
  longint      acc;
  bit          sat;
  int          deg_r;
  int          mm_r;
  bit          blk_r;
  bit          mat_r;
  bit          scale_r;
  int          fails;
  wdsk_pkg::result_t kernel_q [$];

  function new();
    deg_r = 1;
    mm_r = 0;
    blk_r = 0;
    mat_r = 0;
    scale_r = 0;
    fails = 0;
    clear_string();
  endfunction

  function void clear_string();
    for (int k = 0; k < 16; k++) begin
      win_start[k] = 0;
      win_off[k] = 0;
      win_mm[k] = 0;
      win_live[k] = 0;
      win_sum[k] = 0;
    end
    pair_count = 0;
    run_len = -1;
    acc = 0;
    sat = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      wdsk_pkg::REG_DEGREE:     deg_r = val[4:0];
      wdsk_pkg::REG_MAX_MM:     mm_r = val[1:0];
      wdsk_pkg::REG_BLOCK_EN:   blk_r = val[0];
      wdsk_pkg::REG_POS_MATRIX: mat_r = val[0];
      wdsk_pkg::REG_POS_SCALE:  scale_r = val[0];
      default: ;
    endcase
  endfunction

  function longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Saturating add into the 48-bit accumulator
  function void acc_add(longint v);
    longint s;
    s = acc + v;
    if (s > 64'sh7FFF_FFFF_FFFF) begin
      s = 64'sh7FFF_FFFF_FFFF;
      sat = 1;
    end else if (s < -64'sh8000_0000_0000) begin
      s = -64'sh8000_0000_0000;
      sat = 1;
    end
    acc = s;
  endfunction

  // Add a window's sum, scaled by its start weight with floor rounding when scaling is on
  function void close_win(int k);
    longint v;
    longint w;
    logic signed [79:0] a;
    logic signed [79:0] b;
    logic signed [79:0] pr;
    v = win_sum[k];
    if (scale_r) begin
      w = win_start[k] < 256 ? sx(pos_mem[win_start[k]]) : 0;
      a = v;
      b = w;
      pr = a * b;
      pr = pr >>> 16;
      v = longint'(pr);
    end
    acc_add(v);
    win_live[k] = 0;
    win_sum[k] = 0;
    win_off[k] = 0;
    win_mm[k] = 0;
  endfunction

  function void note_item(wdsk_pkg::item_t it);
    int dg;
    int m;
    bit blk;
    bit mat;
    bit eq;
    int slot;
    int idx;
    wdsk_pkg::result_t r;
    dg = deg_r < 1 ? 1 : (deg_r > 16 ? 16 : deg_r);
    m = mm_r > 3 ? 3 : mm_r;
    blk = m == 0 && !mat_r && blk_r;
    mat = m == 0 && mat_r;
    case (it.func)
      wdsk_pkg::FUNC_WT: begin
        wt_mem[it.table_index] = it.table_value;
        return;
      end
      wdsk_pkg::FUNC_POS: begin
        if (it.table_index < 256) pos_mem[it.table_index] = it.table_value;
        return;
      end
      wdsk_pkg::FUNC_BLK: begin
        if (it.table_index < 256) blk_mem[it.table_index] = it.table_value;
        return;
      end
      default: ;
    endcase
    if (pair_count >= 256) begin
      sat = 1;
    end else begin
      eq = it.sym_a == it.sym_b;
      if (blk) begin
        if (eq) begin
          run_len++;
        end else begin
          if (run_len >= 0 && run_len < 256) acc_add(sx(blk_mem[run_len]));
          run_len = -1;
        end
      end else begin
        // Open a window at this position, then advance every live one
        slot = pair_count % 16;
        if (win_live[slot]) close_win(slot);
        win_live[slot] = 1;
        win_start[slot] = pair_count;
        win_off[slot] = 0;
        win_mm[slot] = 0;
        win_sum[slot] = 0;
        for (int k = 0; k < 16; k++) begin
          if (win_live[k]) begin
            if (!eq) win_mm[k]++;
            if (win_mm[k] > m) begin
              close_win(k);
            end else begin
              idx = mat ? win_start[k] * dg + win_off[k] : win_off[k] + dg * win_mm[k];
              if (idx < 4096) win_sum[k] += sx(wt_mem[idx]);
              win_off[k]++;
              if (win_off[k] >= dg) close_win(k);
            end
          end
        end
      end
      pair_count++;
    end
    if (!it.end_of_string) return;
    for (int k = 0; k < 16; k++)
      if (win_live[k]) close_win(k);
    if (run_len >= 0 && run_len < 256) acc_add(sx(blk_mem[run_len]));
    r.kernel_value = acc[47:0];
    r.string_length = pair_count[8:0];
    r.overflow = sat;
    kernel_q.push_back(r);
    clear_string();
  endfunction

  function void check_result(wdsk_pkg::result_t r);
    wdsk_pkg::result_t e;
    if (kernel_q.size() == 0) begin
      $error("unexpected result: kernel_value %0d", r.kernel_value);
      fails++;
      return;
    end
    e = kernel_q.pop_front();
    if (r.kernel_value !== e.kernel_value) begin
      $error("kernel_value: expected %0d, actual %0d", e.kernel_value, r.kernel_value);
      fails++;
    end
    if (r.string_length !== e.string_length) begin
      $error("string_length: expected %0d, actual %0d", e.string_length, r.string_length);
      fails++;
    end
    if (r.overflow !== e.overflow) begin
      $error("overflow: expected %0d, actual %0d", e.overflow, r.overflow);
      fails++;
    end
  endfunction
endclass

module tb_top;
  import wdsk_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        quiet;
  logic        hold_req;
  logic        held;
  int          stall_left;

  kernel_scoreboard sb;

  weighted_degree_string_kernel_top DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: check each transfer, stall at random or for one long hold-off
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (hold_req && !held) begin
      held <= 1;
      stall_left <= 3000;
      result_ready <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 0;
    end else begin
      result_ready <= quiet || $urandom_range(99) >= 18;
    end
  end

  function automatic item_t mk_pair(logic [7:0] a, logic [7:0] b, logic eos);
    item_t it;
    it.func = FUNC_CMP;
    it.sym_a = a;
    it.sym_b = b;
    it.end_of_string = eos;
    it.table_index = 12'($urandom);
    it.table_value = $urandom;
    return it;
  endfunction

  function automatic item_t mk_write(logic [1:0] f, logic [11:0] idx, logic [31:0] val);
    item_t it;
    it.func = f;
    it.sym_a = 8'($urandom);
    it.sym_b = 8'($urandom);
    it.end_of_string = 1'($urandom);
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic logic [31:0] small_val();
    return $urandom_range(99) < 10 ? $urandom : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  // Offer one item, holding it until the transfer; starts and ends on an edge
  task automatic send(item_t it);
    if (!quiet && $urandom_range(99) < 18) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_string(int len, int alpha);
    logic [7:0] a;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      a = alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha));
      b = $urandom_range(99) < 70 ? a : (alpha == 0 ? 8'($urandom) : 8'($urandom_range(alpha)));
      send(mk_pair(a, b, i == len - 1));
    end
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    item_valid <= 0;
    while (sb.kernel_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_mode(int dg, int mm, bit blk, bit mat, bit sc);
    write_reg(REG_DEGREE, dg);
    write_reg(REG_MAX_MM, mm);
    write_reg(REG_BLOCK_EN, blk);
    write_reg(REG_POS_MATRIX, mat);
    write_reg(REG_POS_SCALE, sc);
  endtask

  initial begin
    int cnt;
    int dg_tab [10];
    sb = new();
    rst <= 1;
    item_valid <= 0;
    item <= '0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    quiet <= 0;
    hold_req <= 0;
    held <= 0;
    stall_left <= 0;
    result_ready <= 0;
    dg_tab = '{16, 0, 31, 1, 7, 4, 12, 2, 9, 16};
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Fill every table entry that the stimulus below can reach: strings in
    // the random phases stay under 32 pairs, so matrix indexes stay under 256
    for (int i = 0; i < 256; i++) send(mk_write(FUNC_WT, 12'(i), small_val()));
    for (int i = 0; i < 32; i++) send(mk_write(FUNC_POS, 12'(i), small_val()));
    for (int i = 0; i < 32; i++) send(mk_write(FUNC_BLK, 12'(i), small_val()));

    // Directed: default mode, one-pair string, extreme symbols
    send(mk_pair(8'h00, 8'h00, 1));
    send(mk_pair(8'hFF, 8'hFF, 0));
    send(mk_pair(8'hFF, 8'h00, 0));
    send(mk_pair(8'h00, 8'hFF, 1));
    // Out-of-range position and block writes are ignored
    send(mk_write(FUNC_POS, 12'hFFF, 32'h7FFF_FFFF));
    send(mk_write(FUNC_BLK, 12'h100, 32'h8000_0000));
    // Saturation high then low through position scaling
    set_mode(16, 0, 0, 0, 1);
    for (int i = 0; i < 16; i++) send(mk_write(FUNC_WT, 12'(i), 32'h7FFF_FFFF));
    for (int i = 0; i < 4; i++) send(mk_write(FUNC_POS, 12'(i), 32'h7FFF_FFFF));
    send_string(4, 1);
    for (int i = 0; i < 16; i++) send(mk_write(FUNC_WT, 12'(i), 32'h8000_0000));
    send(mk_pair(8'h11, 8'h11, 0));
    send(mk_pair(8'h22, 8'h22, 1));
    for (int i = 0; i < 16; i++) send(mk_write(FUNC_WT, 12'(i), small_val()));
    for (int i = 0; i < 4; i++) send(mk_write(FUNC_POS, 12'(i), small_val()));
    // String longer than the maximum length, closed on a dropped pair
    set_mode(3, 0, 0, 0, 0);
    send_string(262, 3);

    // Random phases across register settings
    for (int ph = 0; ph < 10; ph++) begin
      set_mode(dg_tab[ph], ph % 4, ph % 3 == 0, ph == 4 || ph == 5 || ph == 8, ph[1]);
      quiet <= ph == 2;
      if (ph == 7) hold_req <= 1;
      cnt = 0;
      while (cnt < 50) begin
        if ($urandom_range(99) < 12) begin
          send(mk_write(2'($urandom_range(1, 3)), 12'($urandom), small_val()));
        end else begin
          int len;
          len = ph == 7 ? $urandom_range(1, 3) : $urandom_range(1, 24);
          send_string(len, $urandom_range(99) < 20 ? 0 : $urandom_range(1, 3));
          cnt += len;
        end
      end
    end

    item_valid <= 0;
    while (sb.kernel_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
